[design/tte_pkg.sv]
// Shared types and constants for the transposition table engine.
// No dependencies; imported by tte_ctrl, tte_dp and transposition_table_engine_top.
package tte_pkg;

    localparam int TABLE_ENTRIES_DEF = 65536;
    localparam int FILL_SAMPLE_DEF   = 1000;

    // operation codes
    localparam logic [2:0] OP_PROBE  = 3'd0;
    localparam logic [2:0] OP_SAVE   = 3'd1;
    localparam logic [2:0] OP_NEWSRCH = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_FILL   = 3'd4;

    // configuration register indexes
    localparam logic CFG_WIN  = 1'b0;
    localparam logic CFG_LOSS = 1'b1;

    localparam logic [1:0] BND_EXACT    = 2'd2;
    localparam logic [8:0] DEPTH_MARGIN = 9'd4;
    localparam logic [9:0] FILL_MAX     = 10'd1023;

    localparam logic [14:0] WIN_RST  = 15'd31754;
    localparam logic [15:0] LOSS_RST = 16'hFFFF - 16'd31753; // -31754

    // slave tdata field offsets
    localparam int IN_W        = 136;
    localparam int IN_KEY_LO   = 0;
    localparam int IN_SCORE_LO = 64;
    localparam int IN_BOUND_LO = 80;
    localparam int IN_DEPTH_LO = 82;
    localparam int IN_MOVE_LO  = 90;
    localparam int IN_EVAL_LO  = 106;
    localparam int IN_PLY_LO   = 122;

    localparam int OUT_W = 72;

    // stored entry: key 63:0, then data word (score, eval, depth, bound, gen)
    localparam int KD_W = 114;

    typedef struct packed {
        logic accept;     // capture beat, read entry
        logic finish;     // complete probe/save/new search/clear/unknown
        logic fill_out;   // load fill tally into result
        logic sweep_zero; // restart sweep counter and tally
        logic clr_wr;     // write zero at sweep address
        logic fill_rd;    // read at sweep address for tally
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       out_free;
        logic       clr_last;
        logic       fill_last;
    } t_status;

endpackage

[design/tte_ctrl.sv]
// Sequencer for the transposition table engine.
// Depends on tte_pkg; drives commands into tte_dp from its status.
module tte_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tte_pkg::t_status  i_st,
    output logic              o_in_ready,
    output tte_pkg::t_cmd     o_cmd
);
    import tte_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_FILL_END,
        S_FILL_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_st.out_free) begin
                    o_cmd.finish = 1'b1;
                    if (i_st.op == OP_CLEAR) begin
                        o_cmd.sweep_zero = 1'b1;
                        n_state = S_CLEAR;
                    end else if (i_st.op == OP_FILL) begin
                        o_cmd.sweep_zero = 1'b1;
                        n_state = S_FILL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FILL: begin
                o_cmd.fill_rd = 1'b1;
                if (i_st.fill_last) begin
                    n_state = S_FILL_END;
                end
            end
            S_FILL_END: begin
                n_state = S_FILL_OUT;
            end
            S_FILL_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.fill_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_EXEC))
        else $error("accepted beat not followed by execute");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) && i_st.clr_last |=> o_in_ready)
        else $error("clearing pass did not return to idle");

    a_no_back_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> !o_cmd.accept)
        else $error("two beats accepted back to back");

    a_fill_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fill_out |-> i_st.out_free && (i_st.op == OP_FILL))
        else $error("fill result loaded into busy slot or for wrong op");

endmodule

[design/tte_dp.sv]
// Datapath of the transposition table engine: entry memories, generation,
// thresholds, save merge, mate score adjustment, fill tally, result register.
// Depends on tte_pkg; sequenced by tte_ctrl.
module tte_dp #(
    parameter int TABLE_ENTRIES = tte_pkg::TABLE_ENTRIES_DEF,
    parameter int FILL_SAMPLE   = tte_pkg::FILL_SAMPLE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tte_pkg::t_cmd            i_cmd,
    output tte_pkg::t_status         o_st,
    input  logic [tte_pkg::IN_W-1:0] i_in_data,
    input  logic [2:0]               i_in_op,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [tte_pkg::OUT_W-1:0] o_out_data,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [15:0]              i_cfg_data
);
    import tte_pkg::*;

    localparam int AW     = $clog2(TABLE_ENTRIES);
    localparam int FILL_N = (TABLE_ENTRIES < FILL_SAMPLE) ? TABLE_ENTRIES : FILL_SAMPLE;

    logic [KD_W-1:0] r_kd_mem [TABLE_ENTRIES];
    logic [15:0]     r_mv_mem [TABLE_ENTRIES];
    logic [KD_W-1:0] r_kd_q;
    logic [15:0]     r_mv_q;

    logic [2:0]  r_op;
    logic [63:0] r_key;
    logic [15:0] r_score, r_move, r_eval;
    logic [1:0]  r_bound;
    logic [7:0]  r_depth, r_ply;
    logic [AW-1:0] r_idx;

    logic [7:0]  r_gen;
    logic [14:0] r_win;
    logic [15:0] r_loss;

    logic [AW-1:0] r_sweep;
    logic          r_fvalid;
    logic [9:0]    r_fcnt;

    logic        r_valid, r_hit;
    logic [15:0] r_o_move, r_o_score, r_o_eval;
    logic [7:0]  r_o_depth;
    logic [1:0]  r_o_bound;
    logic [9:0]  r_o_fill;

    // fields of the read entry
    logic [63:0] q_key;
    logic [15:0] q_score, q_eval;
    logic [7:0]  q_depth, q_gen;
    logic [1:0]  q_bound;
    logic        same, upd_data, upd_move, out_free, load_res;
    logic        is_probe, is_save;
    logic signed [16:0] adj_dn, adj_up;
    logic [15:0] adj_score;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        kd_we, mv_we, rd_en;
    logic [KD_W-1:0] kd_wd;
    logic [15:0] mv_wd;

    assign q_key   = r_kd_q[63:0];
    assign q_score = r_kd_q[79:64];
    assign q_eval  = r_kd_q[95:80];
    assign q_depth = r_kd_q[103:96];
    assign q_bound = r_kd_q[105:104];
    assign q_gen   = r_kd_q[113:106];

    assign is_probe = (r_op == OP_PROBE);
    assign is_save  = (r_op == OP_SAVE);
    assign same     = (q_key == r_key);
    assign upd_move = (r_move != 16'd0) || !same;
    assign upd_data = (r_bound == BND_EXACT) || !same
                   || (({1'b0, r_depth} + DEPTH_MARGIN) > {1'b0, q_depth})
                   || (q_gen != r_gen);

    assign adj_dn = $signed({q_score[15], q_score}) - $signed({9'd0, r_ply});
    assign adj_up = $signed({q_score[15], q_score}) + $signed({9'd0, r_ply});

    always_comb begin
        if ($signed(q_score) >= $signed({1'b0, r_win})) begin
            adj_score = adj_dn[15:0];
        end else if ($signed(q_score) <= $signed(r_loss)) begin
            adj_score = adj_up[15:0];
        end else begin
            adj_score = q_score;
        end
    end

    assign rd_en   = i_cmd.accept || i_cmd.fill_rd;
    assign rd_addr = i_cmd.accept ? i_in_data[IN_KEY_LO +: AW] : r_sweep;
    assign wr_addr = i_cmd.clr_wr ? r_sweep : r_idx;
    assign kd_we   = i_cmd.clr_wr || (i_cmd.finish && is_save && upd_data);
    assign mv_we   = i_cmd.clr_wr || (i_cmd.finish && is_save && upd_move);
    assign kd_wd   = i_cmd.clr_wr ? '0
                   : {r_gen, r_bound, r_depth, r_eval, r_score, r_key};
    assign mv_wd   = i_cmd.clr_wr ? 16'd0 : r_move;

    always_ff @(posedge i_clk) begin
        if (kd_we) begin
            r_kd_mem[wr_addr] <= kd_wd;
        end
        if (rd_en) begin
            r_kd_q <= r_kd_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv_we) begin
            r_mv_mem[wr_addr] <= mv_wd;
        end
        if (rd_en) begin
            r_mv_q <= r_mv_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_in_op;
            r_key   <= i_in_data[IN_KEY_LO +: 64];
            r_score <= i_in_data[IN_SCORE_LO +: 16];
            r_bound <= i_in_data[IN_BOUND_LO +: 2];
            r_depth <= i_in_data[IN_DEPTH_LO +: 8];
            r_move  <= i_in_data[IN_MOVE_LO +: 16];
            r_eval  <= i_in_data[IN_EVAL_LO +: 16];
            r_ply   <= i_in_data[IN_PLY_LO +: 8];
            r_idx   <= i_in_data[IN_KEY_LO +: AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= 8'd0;
        end else if (i_cmd.finish && (r_op == OP_NEWSRCH)) begin
            r_gen <= r_gen + 8'd1;
        end else if (i_cmd.finish && (r_op == OP_CLEAR)) begin
            r_gen <= 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= WIN_RST;
            r_loss <= LOSS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIN:  r_win  <= i_cfg_data[14:0];
                CFG_LOSS: r_loss <= i_cfg_data;
                default:  r_win  <= r_win;
            endcase
        end
    end

    // sweep address and fill tally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep  <= '0;
            r_fvalid <= 1'b0;
            r_fcnt   <= 10'd0;
        end else begin
            r_fvalid <= i_cmd.fill_rd;
            if (i_cmd.sweep_zero) begin
                r_sweep <= '0;
                r_fcnt  <= 10'd0;
            end else begin
                if (i_cmd.clr_wr || i_cmd.fill_rd) begin
                    r_sweep <= r_sweep + AW'(1);
                end
                if (r_fvalid && (q_gen == r_gen) && (q_key != 64'd0)
                        && (r_fcnt != FILL_MAX)) begin
                    r_fcnt <= r_fcnt + 10'd1;
                end
            end
        end
    end

    assign out_free = !r_valid || i_out_ready;
    assign load_res = (i_cmd.finish && (r_op != OP_FILL)) || i_cmd.fill_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_res) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            if (i_cmd.finish && is_probe) begin
                r_hit     <= same;
                r_o_move  <= r_mv_q;
                r_o_score <= adj_score;
                r_o_eval  <= q_eval;
                r_o_depth <= q_depth;
                r_o_bound <= q_bound;
            end else begin
                r_hit     <= 1'b0;
                r_o_move  <= 16'd0;
                r_o_score <= 16'd0;
                r_o_eval  <= 16'd0;
                r_o_depth <= 8'd0;
                r_o_bound <= 2'd0;
            end
            r_o_fill <= i_cmd.fill_out ? r_fcnt : 10'd0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = {3'd0, r_o_fill, r_o_bound, r_o_depth, r_o_eval,
                          r_o_score, r_o_move, r_hit};

    assign o_st.op        = r_op;
    assign o_st.out_free  = out_free;
    assign o_st.clr_last  = (r_sweep == {AW{1'b1}});
    assign o_st.fill_last = (r_sweep == AW'(FILL_N - 1));

endmodule

[design/transposition_table_engine_top.sv]
// Top level of the transposition table engine: stream ports, config port.
// Depends on tte_pkg, tte_ctrl and tte_dp.
//
// Direct-mapped position table of TABLE_ENTRIES entries indexed by the low key
// bits, one beat in and one result beat out per operation. Probe, save, new
// search and unknown ops pass a capture step with the memory read, then an
// execute step that writes back to the entry memories once the output register
// is free. Clear sweeps all TABLE_ENTRIES entries and fill count reads
// min(TABLE_ENTRIES, FILL_SAMPLE) entries, each by a one-entry-per-cycle sweep.
// After reset all TABLE_ENTRIES entries are swept to zero before the first beat is
// taken; configuration writes are accepted at any time. A result waits in an
// output register and does not hold up the next beat's capture.
module transposition_table_engine_top #(
    parameter int TABLE_ENTRIES = tte_pkg::TABLE_ENTRIES_DEF,
    parameter int FILL_SAMPLE   = tte_pkg::FILL_SAMPLE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // pos_key, new_score, new_bound, new_depth, new_move, new_eval, ply, pad
    input  logic [tte_pkg::IN_W-1:0]  s_axis_tdata,
    // op
    input  logic [2:0]                s_axis_tuser,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // hit, entry_move, entry_score, entry_eval, entry_depth, entry_bound,
    // fill_count, pad
    output logic [tte_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [15:0]               i_cfg_data
);
    import tte_pkg::*;

    t_cmd    cmd;
    t_status st;

    tte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_st       (st),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    tte_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FILL_SAMPLE   (FILL_SAMPLE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_in_data   (s_axis_tdata),
        .i_in_op     (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

[verif/transposition_table_engine_top_tb.sv]
// Self-checking testbench for transposition_table_engine_top: stream beats in and out,
// threshold writes, an in-bench table model and a result scoreboard.
// Depends on tte_pkg and the design sources; reads no files.
`timescale 1ns / 1ps

module transposition_table_engine_top_tb;
    import tte_pkg::*;

    localparam logic [2:0] OP_SPARE_0 = 3'd5;
    localparam logic [2:0] OP_SPARE_1 = 3'd6;
    localparam logic [2:0] OP_SPARE_2 = 3'd7;

    localparam logic [1:0] BND_UPPER = 2'd0;
    localparam logic [1:0] BND_LOWER = 2'd1;
    localparam logic [1:0] BND_ODD   = 2'd3;

    localparam int SLOT_COUNT  = TABLE_ENTRIES_DEF;
    localparam int TALLY_SPAN  = (TABLE_ENTRIES_DEF < FILL_SAMPLE_DEF) ?
                                 TABLE_ENTRIES_DEF : FILL_SAMPLE_DEF;
    localparam int IDLE_PAD    = 8;
    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic [63:0] KEY_A   = 64'hA5A5_0000_1234_0005;
    localparam logic [63:0] KEY_B   = 64'h5A5A_FFFF_0000_0005;
    localparam logic [63:0] KEY_C   = 64'h0123_4567_89AB_0010;
    localparam logic [63:0] KEY_D   = 64'hFEDC_BA98_7654_03E7;
    localparam logic [63:0] KEY_E   = 64'h7777_1111_2222_0002;
    localparam logic [63:0] KEY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef bit t_bool;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] key;
        logic [15:0] score;
        logic [1:0]  bound;
        logic [7:0]  depth;
        logic [15:0] move;
        logic [15:0] eval;
        logic [7:0]  ply;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [15:0] move;
        logic [15:0] score;
        logic [15:0] eval;
        logic [7:0]  depth;
        logic [1:0]  bound;
        logic [9:0]  fill;
    } t_resp;

    typedef struct packed {
        logic [7:0]  gen;
        logic [1:0]  bound;
        logic [7:0]  depth;
        logic [15:0] eval;
        logic [15:0] score;
    } t_slot;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic [IN_W-1:0]    s_axis_tdata = '0;
    logic [2:0]         s_axis_tuser = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = 1'b0;
    logic [15:0]        i_cfg_data = '0;

    // table model
    logic [63:0]        slot_key [int];
    t_slot              slot_data [int];
    logic [15:0]        slot_move [int];
    logic [7:0]         search_gen;
    int                 win_lim;
    int                 loss_lim;

    t_resp              results_due [$];
    logic [63:0]        key_pool [32];
    int                 spots [12] = '{0, 1, 2, 5, 16, 511, 998, 999, 1000, 32768, 43690, 65535};
    int                 fail_count = 0;
    int                 cycle_count = 0;
    int                 hold_off_cycles = 0;
    bit                 no_idle = 1'b0;

    transposition_table_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_resp apply_table_op(input t_req r);
        t_resp       res;
        t_slot       cur;
        logic [63:0] held_key;
        logic [15:0] held_move;
        t_bool       same;
        int          idx;
        int          s;
        int          tally;
        res = '0;
        idx = int'(r.key & 64'(SLOT_COUNT - 1));
        cur = '0;
        held_key = '0;
        held_move = '0;
        if (slot_data.exists(idx)) cur = slot_data[idx];
        if (slot_key.exists(idx)) held_key = slot_key[idx];
        if (slot_move.exists(idx)) held_move = slot_move[idx];
        same = (held_key == r.key);
        case (r.op)
            OP_PROBE: begin
                s = int'($signed(cur.score));
                if (s >= win_lim) s = s - int'(r.ply);
                else if (s <= loss_lim) s = s + int'(r.ply);
                res.hit   = same;
                res.move  = held_move;
                res.score = s[15:0];
                res.eval  = cur.eval;
                res.depth = cur.depth;
                res.bound = cur.bound;
            end
            OP_SAVE: begin
                if (r.move != 16'd0 || !same) slot_move[idx] = r.move;
                if (r.bound == BND_EXACT || !same ||
                    int'(r.depth) + int'(DEPTH_MARGIN) > int'(cur.depth) ||
                    cur.gen != search_gen) begin
                    slot_key[idx]  = r.key;
                    slot_data[idx] = '{gen: search_gen, bound: r.bound, depth: r.depth,
                                       eval: r.eval, score: r.score};
                end
            end
            OP_NEWSRCH: search_gen = search_gen + 8'd1;
            OP_CLEAR: begin
                slot_key.delete();
                slot_data.delete();
                slot_move.delete();
                search_gen = '0;
            end
            OP_FILL: begin
                tally = 0;
                for (int i = 0; i < TALLY_SPAN; i++) begin
                    if (slot_key.exists(i) && slot_key[i] != 64'd0 &&
                        slot_data[i].gen == search_gen)
                        tally++;
                end
                if (tally > int'(FILL_MAX)) tally = int'(FILL_MAX);
                res.fill = tally[9:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_req make_req(input logic [2:0] op, input logic [63:0] key,
                                      input logic [15:0] score, input logic [1:0] bound,
                                      input logic [7:0] depth, input logic [15:0] move,
                                      input logic [15:0] eval, input logic [7:0] ply);
        t_req r;
        r = '{op: op, key: key, score: score, bound: bound, depth: depth,
              move: move, eval: eval, ply: ply};
        return r;
    endfunction

    function automatic t_req draw_request();
        t_req r;
        int   pick;
        int   v;
        pick = $urandom_range(0, 99);
        if (pick < 45)      r.op = OP_PROBE;
        else if (pick < 85) r.op = OP_SAVE;
        else if (pick < 89) r.op = OP_NEWSRCH;
        else if (pick < 92) r.op = OP_FILL;
        else if (pick < 94) r.op = OP_SPARE_0;
        else if (pick < 96) r.op = OP_SPARE_1;
        else if (pick < 98) r.op = OP_SPARE_2;
        else                r.op = OP_PROBE;
        pick = $urandom_range(0, 19);
        if (pick < 17)       r.key = key_pool[$urandom_range(0, 31)];
        else if (pick < 19)  r.key = {$urandom, $urandom};
        else                 r.key = '0;
        case ($urandom_range(0, 9))
            3, 4:    v = win_lim + int'($urandom_range(0, 6)) - 3;
            5, 6:    v = loss_lim + int'($urandom_range(0, 6)) - 3;
            7:       v = 32767;
            8:       v = -32768;
            9:       v = int'($urandom_range(0, 200)) - 100;
            default: v = int'($urandom);
        endcase
        r.score = v[15:0];
        r.bound = 2'($urandom_range(0, 3));
        r.depth = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12));
        r.move  = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        r.eval  = 16'($urandom);
        r.ply   = 8'($urandom);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result(input logic [OUT_W-1:0] beat);
        t_resp got;
        t_resp want;
        got.hit   = beat[0];
        got.move  = beat[16:1];
        got.score = beat[32:17];
        got.eval  = beat[48:33];
        got.depth = beat[56:49];
        got.bound = beat[58:57];
        got.fill  = beat[68:59];
        if (results_due.size() == 0) begin
            report_mismatch("unexpected result beat", beat[63:0], '0);
        end else begin
            want = results_due.pop_front();
            if (got.hit != want.hit)
                report_mismatch("hit", 64'(got.hit), 64'(want.hit));
            if (got.move != want.move)
                report_mismatch("entry_move", 64'(got.move), 64'(want.move));
            if (got.score != want.score)
                report_mismatch("entry_score", 64'(got.score), 64'(want.score));
            if (got.eval != want.eval)
                report_mismatch("entry_eval", 64'(got.eval), 64'(want.eval));
            if (got.depth != want.depth)
                report_mismatch("entry_depth", 64'(got.depth), 64'(want.depth));
            if (got.bound != want.bound)
                report_mismatch("entry_bound", 64'(got.bound), 64'(want.bound));
            if (got.fill != want.fill)
                report_mismatch("fill_count", 64'(got.fill), 64'(want.fill));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    end

    // result sink: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int stall;
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid && hold_off_cycles == 0) @(posedge i_clk);
        end
    end

    task automatic send_beat(input t_req r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {6'd0, r.ply, r.eval, r.move, r.depth, r.bound, r.score, r.key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        results_due.push_back(apply_table_op(r));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAD) @(posedge i_clk);
    endtask

    task automatic set_thresholds(input logic [14:0] win, input logic [15:0] loss);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIN;
        i_cfg_data <= {1'b0, win};
        @(posedge i_clk);
        win_lim = int'(win);
        i_cfg_idx  <= CFG_LOSS;
        i_cfg_data <= loss;
        @(posedge i_clk);
        loss_lim = int'($signed(loss));
        i_cfg_we <= 1'b0;
    endtask

    task automatic build_key_pool();
        foreach (key_pool[i]) begin
            key_pool[i] = {$urandom, $urandom};
            key_pool[i][15:0] = 16'(spots[$urandom_range(0, 11)]);
        end
    endtask

    // reset thresholds in force; mate windows, key collisions, move keep, generation age
    task automatic test_directed_ops();
        send_beat(make_req(OP_PROBE, '0, '0, '0, '0, '0, '0, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_MAX, '0, '0, '0, '0, '0, 8'd255));
        send_beat(make_req(OP_SAVE, KEY_A, 16'h7FFF, BND_EXACT, 8'd255, 16'hFFFF,
                           16'h8000, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_A, '0, '0, '0, '0, '0, 8'd255));
        send_beat(make_req(OP_SAVE, KEY_A, 16'd0, BND_LOWER, 8'd0, 16'd0, 16'd1, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_A, '0, '0, '0, '0, '0, 8'd0));
        send_beat(make_req(OP_SAVE, KEY_B, 16'd5, BND_UPPER, 8'd1, 16'd0, 16'd9, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_A, '0, '0, '0, '0, '0, 8'd3));
        send_beat(make_req(OP_SAVE, KEY_B, 16'h8000, BND_ODD, 8'd10, 16'd7, 16'h7FFF, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_B, '0, '0, '0, '0, '0, 8'd200));
        send_beat(make_req(OP_SAVE, KEY_C, 16'd31754, BND_EXACT, 8'd3, 16'd1, 16'd0, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_C, '0, '0, '0, '0, '0, 8'd7));
        send_beat(make_req(OP_SAVE, KEY_D, -16'sd31754, BND_LOWER, 8'd4, 16'd2, 16'd0, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_D, '0, '0, '0, '0, '0, 8'd7));
        send_beat(make_req(OP_SAVE, KEY_D, 16'd31753, BND_UPPER, 8'd20, 16'd3, 16'd4, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_D, '0, '0, '0, '0, '0, 8'd9));
        send_beat(make_req(OP_SAVE, KEY_MAX, 16'hFFFF, BND_ODD, 8'hFF, 16'hFFFF, 16'hFFFF,
                           8'hFF));
        send_beat(make_req(OP_PROBE, KEY_MAX, '0, '0, '0, '0, '0, 8'hFF));
        send_beat(make_req(OP_NEWSRCH, '0, '0, '0, '0, '0, '0, 8'd0));
        send_beat(make_req(OP_SAVE, KEY_C, 16'd100, BND_UPPER, 8'd0, 16'd0, 16'd5, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_C, '0, '0, '0, '0, '0, 8'd1));
        send_beat(make_req(OP_FILL, '0, '0, '0, '0, '0, '0, 8'd0));
        send_beat(make_req(OP_SPARE_0, KEY_A, 16'hFFFF, BND_EXACT, 8'd1, 16'd1, 16'd1, 8'd1));
        send_beat(make_req(OP_SPARE_1, KEY_C, '0, '0, '0, '0, '0, 8'd0));
        send_beat(make_req(OP_SPARE_2, KEY_MAX, '0, '0, '0, '0, '0, 8'd0));
        send_beat(make_req(OP_CLEAR, '0, '0, '0, '0, '0, '0, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_A, '0, '0, '0, '0, '0, 8'd5));
        send_beat(make_req(OP_FILL, '0, '0, '0, '0, '0, '0, 8'd0));
        wait_idle();
    endtask

    // 256 new searches bring the generation back round to where it was
    task automatic test_generation_wrap();
        send_beat(make_req(OP_SAVE, KEY_E, 16'd50, BND_LOWER, 8'd200, 16'd33, 16'd8, 8'd0));
        no_idle = 1'b1;
        repeat (256) send_beat(make_req(OP_NEWSRCH, '0, '0, '0, '0, '0, '0, 8'd0));
        no_idle = 1'b0;
        send_beat(make_req(OP_SAVE, KEY_E, 16'd60, BND_UPPER, 8'd0, 16'd0, 16'd9, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_E, '0, '0, '0, '0, '0, 8'd0));
        send_beat(make_req(OP_FILL, '0, '0, '0, '0, '0, '0, 8'd0));
        send_beat(make_req(OP_NEWSRCH, '0, '0, '0, '0, '0, '0, 8'd0));
        send_beat(make_req(OP_SAVE, KEY_E, 16'd70, BND_UPPER, 8'd0, 16'd0, 16'd10, 8'd0));
        send_beat(make_req(OP_PROBE, KEY_E, '0, '0, '0, '0, '0, 8'd0));
        wait_idle();
    endtask

    // sink holds off while the source keeps offering, so the input must stall
    task automatic test_backpressure();
        hold_off_cycles = 300;
        no_idle = 1'b1;
        repeat (40) send_beat(draw_request());
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n_items, input logic [14:0] win,
                                       input logic [15:0] loss, input bit wipe);
        t_req r;
        set_thresholds(win, loss);
        if (wipe) send_beat(make_req(OP_CLEAR, '0, '0, '0, '0, '0, '0, 8'd0));
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            r = draw_request();
            send_beat(r);
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    initial begin
        search_gen = '0;
        win_lim    = int'(WIN_RST);
        loss_lim   = int'($signed(LOSS_RST));
        build_key_pool();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_generation_wrap();
        test_backpressure();
        test_random_traffic(320, 15'd0, 16'd0, 1'b0);
        test_random_traffic(320, 15'h7FFF, 16'h8000, 1'b1);
        test_random_traffic(320, 15'($urandom), {1'b1, 15'($urandom)}, 1'b0);
        test_random_traffic(320, WIN_RST, LOSS_RST, 1'b1);

        repeat (20) @(posedge i_clk);
        if (results_due.size() != 0)
            report_mismatch("results still outstanding", 64'(results_due.size()), '0);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
